// ===== rtl/lrp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrp_pkg
// Shared types and constants of the five-point laplacian residual core.
// ---------------------------------------------------------------------------
package lrp_pkg;

  // input function codes
  typedef enum logic [1:0] {
    FN_LOAD_CELL = 2'd0,
    FN_LOAD_EDGE = 2'd1,
    FN_QUERY     = 2'd2,
    FN_CLEAR     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CMD_LOAD_CELL = 2'd0,
    CMD_LOAD_EDGE = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_kind_t;

  // stencil used along one axis
  typedef enum logic [2:0] {
    ST_INNER  = 3'd0,
    ST_LO_NEU = 3'd1,
    ST_LO_DIR = 3'd2,
    ST_HI_NEU = 3'd3,
    ST_HI_DIR = 3'd4
  } stencil_t;

  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_E = 2'd1;
  localparam logic [1:0] SIDE_S = 2'd2;
  localparam logic [1:0] SIDE_W = 2'd3;

  localparam logic [2:0] CFG_GRID_SIZE = 3'd0;
  localparam logic [2:0] CFG_NBR_MASK  = 3'd1;
  localparam logic [2:0] CFG_NEUMANN   = 3'd2;
  localparam logic [2:0] CFG_INV_HX    = 3'd3;
  localparam logic [2:0] CFG_INV_HX_SQ = 3'd4;
  localparam logic [2:0] CFG_INV_HY    = 3'd5;
  localparam logic [2:0] CFG_INV_HY_SQ = 3'd6;

  // cells per side of the grid store, matches the 6-bit row and column fields
  localparam int MAX_GRID = 64;

  localparam int NUM_W  = 36;              // stencil numerator
  localparam int PROD_W = NUM_W + 33;      // numerator times unsigned coefficient
  localparam int LAP_W  = PROD_W + 2;      // sum of four products
  localparam int RES_W  = LAP_W + 1;

  typedef struct packed {
    logic [6:0]  grid_size;
    logic [3:0]  nbr_mask;
    logic        neumann;
    logic [31:0] inv_hx;
    logic [31:0] inv_hx_sq;
    logic [31:0] inv_hy;
    logic [31:0] inv_hy_sq;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [1:0]  side;
    logic [5:0]  pos;
    logic [31:0] sol;
    logic [31:0] src;
    logic [31:0] bound;
    stencil_t    x_mode;
    stencil_t    y_mode;
    logic        w_edge;
    logic        e_edge;
    logic        s_edge;
    logic        n_edge;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic acc_fire;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lrp_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrp_front
// Accepts items, drops the ones with no effect, works out the edge stencils
// of a query and queues the command for the back end (two entries).
// ---------------------------------------------------------------------------
module lrp_front import lrp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_func,
  input  wire logic [5:0]  in_cell_row,
  input  wire logic [5:0]  in_cell_col,
  input  wire logic [1:0]  in_edge_side,
  input  wire logic [5:0]  in_edge_pos,
  input  wire logic [31:0] in_sol_value,
  input  wire logic [31:0] in_src_value,
  input  wire logic [31:0] in_bound_value,
  output cmd_t             q_cmd,
  output logic             q_valid,
  input  wire logic        q_pop
);

  logic [8:0] gs9, max9, n9, row9, col9, pos9, last9;
  logic       keep, push_q;
  cmd_t       new_cmd;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    gs9  = {2'b00, cfg.grid_size};
    max9 = 9'(MAX_GRID);
    if (gs9 < 9'd3) begin
      n9 = 9'd3;
    end else if (gs9 > max9) begin
      n9 = max9;
    end else begin
      n9 = gs9;
    end
    last9 = n9 - 9'd1;
    row9  = {3'b000, in_cell_row};
    col9  = {3'b000, in_cell_col};
    pos9  = {3'b000, in_edge_pos};

    new_cmd        = '0;
    new_cmd.row    = in_cell_row;
    new_cmd.col    = in_cell_col;
    new_cmd.side   = in_edge_side;
    new_cmd.pos    = in_edge_pos;
    new_cmd.sol    = in_sol_value;
    new_cmd.src    = in_src_value;
    new_cmd.bound  = in_bound_value;
    new_cmd.w_edge = (col9 == 9'd0);
    new_cmd.e_edge = (col9 == last9);
    new_cmd.s_edge = (row9 == 9'd0);
    new_cmd.n_edge = (row9 == last9);

    // low side is checked first, matching the stencil priority
    if (new_cmd.w_edge && !cfg.nbr_mask[SIDE_W]) begin
      new_cmd.x_mode = cfg.neumann ? ST_LO_NEU : ST_LO_DIR;
    end else if (new_cmd.e_edge && !cfg.nbr_mask[SIDE_E]) begin
      new_cmd.x_mode = cfg.neumann ? ST_HI_NEU : ST_HI_DIR;
    end else begin
      new_cmd.x_mode = ST_INNER;
    end
    if (new_cmd.s_edge && !cfg.nbr_mask[SIDE_S]) begin
      new_cmd.y_mode = cfg.neumann ? ST_LO_NEU : ST_LO_DIR;
    end else if (new_cmd.n_edge && !cfg.nbr_mask[SIDE_N]) begin
      new_cmd.y_mode = cfg.neumann ? ST_HI_NEU : ST_HI_DIR;
    end else begin
      new_cmd.y_mode = ST_INNER;
    end

    case (func_t'(in_func))
      FN_LOAD_CELL: begin
        new_cmd.kind = CMD_LOAD_CELL;
        keep = (row9 < max9) && (col9 < max9);
      end
      FN_LOAD_EDGE: begin
        new_cmd.kind = CMD_LOAD_EDGE;
        keep = (pos9 < max9);
      end
      FN_QUERY: begin
        new_cmd.kind = CMD_QUERY;
        keep = (row9 < n9) && (col9 < n9);
      end
      FN_CLEAR: begin
        new_cmd.kind = CMD_CLEAR;
        keep = 1'b1;
      end
      default: begin
        new_cmd.kind = CMD_CLEAR;
        keep = 1'b0;
      end
    endcase
  end

  assign in_full = (count_r == 2'd2);
  assign push_q  = in_push && !in_full && keep;
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_q ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_q} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lrp_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrp_back
// Executes queued commands: grid and boundary stores, the stencil gather,
// a shared multiplier, saturation, squaring, the running sum and the result
// register.
// ---------------------------------------------------------------------------
module lrp_back import lrp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire cmd_t         q_cmd,
  input  wire logic         q_valid,
  output logic              q_pop,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic signed [31:0] out_resid_value,
  output logic [62:0]       out_sum_squares,
  output logic              out_saturated,
  output back_stat_t        stat
);

  localparam int AW = $clog2(MAX_GRID * MAX_GRID);
  localparam int EW = $clog2(4 * MAX_GRID);
  localparam logic signed [RES_W-1:0] RMAX = RES_W'(64'sh7FFF_FFFF);
  localparam logic signed [RES_W-1:0] RMIN = -RMAX - RES_W'(1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_NUM  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_SAT  = 7'b0010000,
    S_SQ   = 7'b0100000,
    S_ACC  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  cmd_t cmd_r;

  logic [31:0] sol_mem  [MAX_GRID * MAX_GRID];
  logic [31:0] src_mem  [MAX_GRID * MAX_GRID];
  logic [31:0] edge_mem [4 * MAX_GRID];
  logic [31:0] sol_rd_r, src_rd_r, edge_rd_r;
  logic [AW-1:0] sol_ra, cell_wa;
  logic [EW-1:0] edge_ra, edge_wa;

  logic signed [31:0] c_r, w_r, e_r, s_r, n_r, f_r, ew_r, ee_r, es_r, en_r;
  logic signed [NUM_W-1:0] nx_r, bx_r, ny_r, by_r, op;
  logic [31:0] coef;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [LAP_W-1:0]  lap_r;
  logic signed [RES_W-1:0]  res_full, res_sh;
  logic signed [31:0] res_r;
  logic sat_r;
  logic [31:0] mag;
  logic [63:0] sq_full, acc_sum;
  logic [62:0] sq_r, acc_r;
  logic slot_free, acc_fire;
  logic signed [NUM_W-1:0] lo_x, hi_x, lo_y, hi_y, cc;

  logic out_valid_r;
  logic signed [31:0] out_resid_r;
  logic [62:0] out_sum_r;
  logic out_sat_r;

  function automatic logic [AW-1:0] cell_addr(input logic [5:0] r, input logic [5:0] c);
    return AW'(AW'(r) * AW'(MAX_GRID) + AW'(c));
  endfunction

  function automatic logic [EW-1:0] edge_addr(input logic [1:0] sd, input logic [5:0] p);
    return EW'(EW'(sd) * EW'(MAX_GRID) + EW'(p));
  endfunction

  function automatic logic signed [NUM_W-1:0] sq_term(input stencil_t m,
      input logic signed [NUM_W-1:0] lo, input logic signed [NUM_W-1:0] c,
      input logic signed [NUM_W-1:0] hi);
    case (m)
      ST_LO_NEU: return hi - c;
      ST_LO_DIR: return (lo <<< 1) - (c + (c <<< 1)) + hi;
      ST_HI_NEU: return lo - c;
      ST_HI_DIR: return lo - (c + (c <<< 1)) + (hi <<< 1);
      default:   return lo - (c <<< 1) + hi;
    endcase
  endfunction

  function automatic logic signed [NUM_W-1:0] lin_term(input stencil_t m,
      input logic signed [NUM_W-1:0] lo, input logic signed [NUM_W-1:0] hi);
    case (m)
      ST_LO_NEU: return -lo;
      ST_HI_NEU: return hi;
      default:   return '0;
    endcase
  endfunction

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign slot_free = !out_valid_r || out_pop;
  assign acc_fire  = (state_r == S_ACC) && slot_free;
  assign stat.busy = (state_r != S_IDLE);
  assign stat.acc_fire = acc_fire;

  // store addresses
  always_comb begin
    cell_wa = cell_addr(q_cmd.row, q_cmd.col);
    edge_wa = edge_addr(q_cmd.side, q_cmd.pos);
    case (step_r)
      3'd0:    sol_ra = cell_addr(cmd_r.row, cmd_r.col);
      3'd1:    sol_ra = cell_addr(cmd_r.row, cmd_r.col - 6'd1);
      3'd2:    sol_ra = cell_addr(cmd_r.row, cmd_r.col + 6'd1);
      3'd3:    sol_ra = cell_addr(cmd_r.row - 6'd1, cmd_r.col);
      default: sol_ra = cell_addr(cmd_r.row + 6'd1, cmd_r.col);
    endcase
    case (step_r)
      3'd0:    edge_ra = edge_addr(SIDE_W, cmd_r.row);
      3'd1:    edge_ra = edge_addr(SIDE_E, cmd_r.row);
      3'd2:    edge_ra = edge_addr(SIDE_S, cmd_r.col);
      default: edge_ra = edge_addr(SIDE_N, cmd_r.col);
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == CMD_LOAD_CELL) begin
      sol_mem[cell_wa] <= q_cmd.sol;
      src_mem[cell_wa] <= q_cmd.src;
    end
    if (q_pop && q_cmd.kind == CMD_LOAD_EDGE) begin
      edge_mem[edge_wa] <= q_cmd.bound;
    end
    sol_rd_r  <= sol_mem[sol_ra];
    src_rd_r  <= src_mem[sol_ra];
    edge_rd_r <= edge_mem[edge_ra];
  end

  // datapath
  always_comb begin
    lo_x = cmd_r.w_edge ? NUM_W'(ew_r) : NUM_W'(w_r);
    hi_x = cmd_r.e_edge ? NUM_W'(ee_r) : NUM_W'(e_r);
    lo_y = cmd_r.s_edge ? NUM_W'(es_r) : NUM_W'(s_r);
    hi_y = cmd_r.n_edge ? NUM_W'(en_r) : NUM_W'(n_r);
    cc   = NUM_W'(c_r);
    case (step_r)
      3'd0: begin
        op = nx_r;
        coef = cfg.inv_hx_sq;
      end
      3'd1: begin
        op = bx_r;
        coef = cfg.inv_hx;
      end
      3'd2: begin
        op = ny_r;
        coef = cfg.inv_hy_sq;
      end
      default: begin
        op = by_r;
        coef = cfg.inv_hy;
      end
    endcase
    res_full = (RES_W'(f_r) <<< 8) - RES_W'(lap_r);
    res_sh   = res_full >>> 8;
    mag      = res_r[31] ? (~res_r + 32'd1) : res_r;
    sq_full  = {32'd0, mag} * {32'd0, mag};
    acc_sum  = {1'b0, acc_r} + {1'b0, sq_r};
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          cmd_r <= q_cmd;
        end
      end
      S_READ: begin
        case (step_r)
          3'd1: begin
            c_r  <= sol_rd_r;
            f_r  <= src_rd_r;
            ew_r <= edge_rd_r;
          end
          3'd2: begin
            w_r  <= sol_rd_r;
            ee_r <= edge_rd_r;
          end
          3'd3: begin
            e_r  <= sol_rd_r;
            es_r <= edge_rd_r;
          end
          3'd4: begin
            s_r  <= sol_rd_r;
            en_r <= edge_rd_r;
          end
          3'd5: begin
            n_r <= sol_rd_r;
          end
          default: begin
          end
        endcase
      end
      S_NUM: begin
        nx_r <= sq_term(cmd_r.x_mode, lo_x, cc, hi_x);
        bx_r <= lin_term(cmd_r.x_mode, lo_x, hi_x);
        ny_r <= sq_term(cmd_r.y_mode, lo_y, cc, hi_y);
        by_r <= lin_term(cmd_r.y_mode, lo_y, hi_y);
      end
      S_MUL: begin
        prod_r <= op * $signed({1'b0, coef});
        // one product behind the multiplier
        if (step_r == 3'd0) begin
          lap_r <= '0;
        end else begin
          lap_r <= lap_r + LAP_W'(prod_r);
        end
      end
      S_SAT: begin
        if (res_sh > RMAX) begin
          res_r <= 32'sh7FFF_FFFF;
          sat_r <= 1'b1;
        end else if (res_sh < RMIN) begin
          res_r <= 32'sh8000_0000;
          sat_r <= 1'b1;
        end else begin
          res_r <= res_sh[31:0];
          sat_r <= 1'b0;
        end
      end
      S_SQ: begin
        sq_r <= sq_full[62:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = 3'd0;
        if (q_pop && q_cmd.kind == CMD_QUERY) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (step_r == 3'd5) begin
          state_nxt = S_NUM;
          step_nxt  = 3'd0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_NUM: begin
        state_nxt = S_MUL;
        step_nxt  = 3'd0;
      end
      S_MUL: begin
        if (step_r == 3'd4) begin
          state_nxt = S_SAT;
          step_nxt  = 3'd0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_SAT: state_nxt = S_SQ;
      S_SQ:  state_nxt = S_ACC;
      S_ACC: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        step_nxt  = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 3'd0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (q_pop && q_cmd.kind == CMD_CLEAR) begin
        acc_r <= '0;
      end else if (acc_fire) begin
        acc_r <= acc_sum[63] ? '1 : acc_sum[62:0];
      end
      if (acc_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire) begin
      out_resid_r <= res_r;
      out_sum_r   <= acc_sum[63] ? '1 : acc_sum[62:0];
      out_sat_r   <= sat_r || acc_sum[63];
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_resid_value = out_resid_r;
  assign out_sum_squares = out_sum_r;
  assign out_saturated   = out_sat_r;

endmodule

`default_nettype wire

// ===== rtl/laplacian_residual_5pt_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// laplacian_residual_5pt_core
// Five-point laplacian residual engine with a running sum of squares.
// ---------------------------------------------------------------------------
// Load, boundary-load and clear items are taken in the back end's idle state.
// A query reads the center and four neighbours through the single read port
// of the solution store (one read a cycle), forms the stencil numerators,
// passes four products through the shared 36 by 33 bit multiplier, then
// saturates, squares and accumulates. A two-entry command queue sits between
// the input side and the back end, and a finished result waits in an output
// register while the next items are taken. Stores come up undefined after
// reset and need no clearing pass; the sum of squares resets to zero.
module laplacian_residual_5pt_core import lrp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_func,
  input  wire logic [5:0]  in_cell_row,
  input  wire logic [5:0]  in_cell_col,
  input  wire logic [1:0]  in_edge_side,
  input  wire logic [5:0]  in_edge_pos,
  input  wire logic signed [31:0] in_sol_value,
  input  wire logic signed [31:0] in_src_value,
  input  wire logic signed [31:0] in_bound_value,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic signed [31:0] out_resid_value,
  output logic [62:0]      out_sum_squares,
  output logic             out_saturated
);

  cfg_t       cfg_r;
  cmd_t       q_cmd;
  logic       q_valid, q_pop;
  back_stat_t bstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_size <= 7'd64;
      cfg_r.nbr_mask  <= 4'd0;
      cfg_r.neumann   <= 1'b0;
      cfg_r.inv_hx    <= 32'd256;
      cfg_r.inv_hx_sq <= 32'd256;
      cfg_r.inv_hy    <= 32'd256;
      cfg_r.inv_hy_sq <= 32'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIZE: cfg_r.grid_size <= cfg_data[6:0];
        CFG_NBR_MASK:  cfg_r.nbr_mask  <= cfg_data[3:0];
        CFG_NEUMANN:   cfg_r.neumann   <= cfg_data[0];
        CFG_INV_HX:    cfg_r.inv_hx    <= cfg_data;
        CFG_INV_HX_SQ: cfg_r.inv_hx_sq <= cfg_data;
        CFG_INV_HY:    cfg_r.inv_hy    <= cfg_data;
        CFG_INV_HY_SQ: cfg_r.inv_hy_sq <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lrp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .in_edge_side   (in_edge_side),
    .in_edge_pos    (in_edge_pos),
    .in_sol_value   (in_sol_value),
    .in_src_value   (in_src_value),
    .in_bound_value (in_bound_value),
    .q_cmd          (q_cmd),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  lrp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_cmd           (q_cmd),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_resid_value (out_resid_value),
    .out_sum_squares (out_sum_squares),
    .out_saturated   (out_saturated),
    .stat            (bstat)
  );

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a result only shows up from the accumulate step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(bstat.acc_fire))
    else $error("result appeared without accumulate");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_saturated) |->
      (out_resid_value == 32'sh7FFF_FFFF || out_resid_value == 32'sh8000_0000 ||
       out_sum_squares == 63'h7FFF_FFFF_FFFF_FFFF))
    else $error("saturated flag without a clipped value");

endmodule

`default_nettype wire

// ===== tb/tb_laplacian_residual_5pt_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tb_laplacian_residual_5pt_core
// Self-checking bench for the five-point laplacian residual core. A local
// predictor keeps its own copy of the grids, edge arrays, sum of squares and
// registers, and works out each query result when the item is taken. A
// checker compares every result transfer field by field with the oldest
// prediction. Both queue sides stall at random while grids of several sizes,
// edge conditions and coefficient settings are exercised.
// ---------------------------------------------------------------------------
module tb_laplacian_residual_5pt_core;
  import lrp_pkg::*;

  localparam int           GRID_MAX   = 64;
  localparam int           CYCLE_CAP  = 300000;
  localparam int           SETTLE     = 80;
  localparam logic [62:0]  SUM_TOP    = {63{1'b1}};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_func = FN_CLEAR;
  logic [5:0]  in_cell_row = '0;
  logic [5:0]  in_cell_col = '0;
  logic [1:0]  in_edge_side = '0;
  logic [5:0]  in_edge_pos = '0;
  logic signed [31:0] in_sol_value = '0;
  logic signed [31:0] in_src_value = '0;
  logic signed [31:0] in_bound_value = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic signed [31:0] out_resid_value;
  logic [62:0] out_sum_squares;
  logic        out_saturated;

  laplacian_residual_5pt_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_func(in_func),
    .in_cell_row(in_cell_row), .in_cell_col(in_cell_col),
    .in_edge_side(in_edge_side), .in_edge_pos(in_edge_pos),
    .in_sol_value(in_sol_value), .in_src_value(in_src_value),
    .in_bound_value(in_bound_value),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_resid_value(out_resid_value), .out_sum_squares(out_sum_squares),
    .out_saturated(out_saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic signed [31:0] resid;
    logic [62:0]        sum;
    logic               sat;
  } resid_t;

  resid_t resid_q[$];
  int     errors = 0;
  int     cycles = 0;

  // predictor state
  logic signed [31:0] sol_m [GRID_MAX*GRID_MAX];
  logic signed [31:0] src_m [GRID_MAX*GRID_MAX];
  logic signed [31:0] edge_m [4*GRID_MAX];
  logic [62:0] accum_m;
  logic [6:0]  gsize_m;
  logic [3:0]  nbr_m;
  logic        neu_m;
  logic [31:0] ihx_m, ihx2_m, ihy_m, ihy2_m;

  function automatic int grid_n();
    return gsize_m < 3 ? 3 : (gsize_m > GRID_MAX ? GRID_MAX : int'(gsize_m));
  endfunction

  function automatic logic signed [127:0] coef_mul(longint v, logic [31:0] c);
    logic signed [127:0] a, b;
    a = v;
    b = {96'd0, c};
    return a * b;
  endfunction

  function automatic void axis_stencil(input int k, input int n, input longint lo_v,
      input longint c, input longint hi_v, input logic lo_nbr, input logic hi_nbr,
      output longint sq, output longint lin);
    lin = 0;
    if (k == 0 && !lo_nbr) begin
      if (neu_m) begin
        sq = hi_v - c;
        lin = -lo_v;
      end else begin
        sq = 2 * lo_v - 3 * c + hi_v;
      end
    end else if (k == n - 1 && !hi_nbr) begin
      if (neu_m) begin
        sq = lo_v - c;
        lin = hi_v;
      end else begin
        sq = lo_v - 3 * c + 2 * hi_v;
      end
    end else begin
      sq = lo_v - 2 * c + hi_v;
    end
  endfunction

  function automatic longint sol_at(int row, int col);
    return longint'(sol_m[row*GRID_MAX + col]);
  endfunction

  // residual of one cell; also advances the sum of squares
  function automatic resid_t cell_residual(int row, int col);
    int n;
    longint c, lo_v, hi_v, nx, bx, ny, by, r;
    logic signed [127:0] lap, res, sh;
    logic [63:0] mag, sq;
    resid_t o;
    n = grid_n();
    o.sat = 1'b0;
    c = sol_at(row, col);
    lo_v = col == 0 ? longint'(edge_m[SIDE_W*GRID_MAX + row]) : sol_at(row, col - 1);
    hi_v = col == n-1 ? longint'(edge_m[SIDE_E*GRID_MAX + row]) : sol_at(row, col + 1);
    axis_stencil(col, n, lo_v, c, hi_v, nbr_m[SIDE_W], nbr_m[SIDE_E], nx, bx);
    lo_v = row == 0 ? longint'(edge_m[SIDE_S*GRID_MAX + col]) : sol_at(row - 1, col);
    hi_v = row == n-1 ? longint'(edge_m[SIDE_N*GRID_MAX + col]) : sol_at(row + 1, col);
    axis_stencil(row, n, lo_v, c, hi_v, nbr_m[SIDE_S], nbr_m[SIDE_N], ny, by);
    lap = coef_mul(nx, ihx2_m) + coef_mul(bx, ihx_m) + coef_mul(ny, ihy2_m)
        + coef_mul(by, ihy_m);
    res = src_m[row*GRID_MAX + col];
    res = (res <<< 8) - lap;
    sh = res >>> 8;
    if (sh > 128'sh7fffffff) begin
      r = 64'sh7fffffff;
      o.sat = 1'b1;
    end else if (sh < -128'sh80000000) begin
      r = -64'sh80000000;
      o.sat = 1'b1;
    end else begin
      r = longint'(sh);
    end
    mag = r < 0 ? -r : r;
    sq = mag * mag;
    if (sq > {1'b0, SUM_TOP - accum_m}) begin
      accum_m = SUM_TOP;
      o.sat = 1'b1;
    end else begin
      accum_m = accum_m + sq[62:0];
    end
    o.resid = r[31:0];
    o.sum = accum_m;
    return o;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $urandom();
      default: return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 19))
      0: return $urandom_range(10, 40);
      1, 2, 3, 4: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  // one item: optional gap, then hold push until the transfer
  task automatic send_item(func_t f, int row, int col, int side, int pos,
                           logic signed [31:0] sol, logic signed [31:0] src,
                           logic signed [31:0] bound);
    int g;
    // the ports carry only the low bits
    row = row & 63;
    col = col & 63;
    side = side & 3;
    pos = pos & 63;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push = 1'b1;
    in_func = f;
    in_cell_row = row[5:0];
    in_cell_col = col[5:0];
    in_edge_side = side[1:0];
    in_edge_pos = pos[5:0];
    in_sol_value = sol;
    in_src_value = src;
    in_bound_value = bound;
    do @(posedge clk); while (in_full);
    case (f)
      FN_LOAD_CELL: begin
        sol_m[row*GRID_MAX + col] = sol;
        src_m[row*GRID_MAX + col] = src;
      end
      FN_LOAD_EDGE: edge_m[side*GRID_MAX + pos] = bound;
      FN_CLEAR: accum_m = '0;
      default: if (row < grid_n() && col < grid_n()) resid_q.push_back(cell_residual(row, col));
    endcase
  endtask

  task automatic load_cell(int row, int col);
    send_item(FN_LOAD_CELL, row, col, $urandom_range(0, 3), $urandom_range(0, 63),
              pick_value(), pick_value(), pick_value());
  endtask

  task automatic load_edge(int side, int pos);
    send_item(FN_LOAD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63), side, pos,
              pick_value(), pick_value(), pick_value());
  endtask

  task automatic query(int row, int col);
    send_item(FN_QUERY, row, col, $urandom_range(0, 3), $urandom_range(0, 63),
              pick_value(), pick_value(), pick_value());
  endtask

  task automatic clear_sum();
    send_item(FN_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
              $urandom_range(0, 3), $urandom_range(0, 63),
              pick_value(), pick_value(), pick_value());
  endtask

  // stop sending and wait until the block has gone quiet
  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    while (resid_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_GRID_SIZE: gsize_m = val[6:0];
      CFG_NBR_MASK:  nbr_m = val[3:0];
      CFG_NEUMANN:   neu_m = val[0];
      CFG_INV_HX:    ihx_m = val;
      CFG_INV_HX_SQ: ihx2_m = val;
      CFG_INV_HY:    ihy_m = val;
      CFG_INV_HY_SQ: ihy2_m = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [6:0] gs, logic [3:0] mask, logic neu,
                            logic [31:0] hx, logic [31:0] hx2,
                            logic [31:0] hy, logic [31:0] hy2);
    write_reg(CFG_GRID_SIZE, {25'd0, gs});
    write_reg(CFG_NBR_MASK, {28'd0, mask});
    write_reg(CFG_NEUMANN, {31'd0, neu});
    write_reg(CFG_INV_HX, hx);
    write_reg(CFG_INV_HX_SQ, hx2);
    write_reg(CFG_INV_HY, hy);
    write_reg(CFG_INV_HY_SQ, hy2);
  endtask

  // everything a query inside the active grid can read
  task automatic fill_grid();
    int n;
    n = grid_n();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) load_cell(r, c);
    for (int s = 0; s < 4; s++)
      for (int p = 0; p < n; p++) load_edge(s, p);
  endtask

  // the center, its neighbours and the edge entries one query reads
  task automatic load_around(int row, int col);
    int n;
    n = grid_n();
    load_cell(row, col);
    if (col > 0) load_cell(row, col - 1); else load_edge(SIDE_W, row);
    if (col < n - 1) load_cell(row, col + 1); else load_edge(SIDE_E, row);
    if (row > 0) load_cell(row - 1, col); else load_edge(SIDE_S, col);
    if (row < n - 1) load_cell(row + 1, col); else load_edge(SIDE_N, col);
  endtask

  task automatic query_at(int row, int col);
    load_around(row, col);
    query(row, col);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return $urandom();
      default: return $urandom_range(1, 2048);
    endcase
  endfunction

  task automatic test_full_grid_defaults();
    int n;
    n = grid_n();
    query_at(0, 0); query_at(0, n-1); query_at(n-1, 0); query_at(n-1, n-1);
    query_at(0, 17); query_at(33, 0); query_at(n-1, 40); query_at(21, n-1);
    for (int i = 0; i < 8; i++) query_at($urandom_range(1, n-2), $urandom_range(1, n-2));
    drain();
  endtask

  task automatic test_edge_stencils();
    set_config(7'd3, 4'd0, 1'b0, 32'd256, 32'd256, 32'd256, 32'd256);
    fill_grid();
    for (int m = 0; m < 16; m++) begin
      for (int neu = 0; neu < 2; neu++) begin
        drain();
        write_reg(CFG_NBR_MASK, m);
        write_reg(CFG_NEUMANN, neu);
        query($urandom_range(0, 2), $urandom_range(0, 2));
        query(m % 3, 2 - m % 3);
      end
    end
    // outside the active grid: no result
    query(3, 0); query(0, 63); query(63, 63);
    clear_sum();
    query(1, 1);
    drain();
  endtask

  task automatic test_saturation();
    set_config(7'd3, 4'd0, 1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(FN_LOAD_CELL, r, c, 0, 0, (r + c) % 2 ? 32'sh7fffffff : 32'sh80000000,
                  32'sh80000000, 0);
    for (int s = 0; s < 4; s++)
      for (int p = 0; p < 3; p++)
        send_item(FN_LOAD_EDGE, 0, 0, s, p, 0, 0, s % 2 ? 32'sh80000000 : 32'sh7fffffff);
    for (int i = 0; i < 6; i++) query(i % 3, (i + 1) % 3);
    clear_sum();
    query(1, 1);
    drain();
    write_reg(CFG_NEUMANN, 1);
    write_reg(CFG_INV_HX, 0);
    write_reg(CFG_INV_HY_SQ, 0);
    for (int i = 0; i < 4; i++) query(i % 3, i % 2);
    drain();
  endtask

  task automatic test_grid_size_clamp();
    logic [6:0] sizes [6] = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd65, 7'd5};
    foreach (sizes[i]) begin
      drain();
      write_reg(CFG_GRID_SIZE, {25'd0, sizes[i]});
      if (grid_n() != GRID_MAX) fill_grid();
      query_at(0, 0);
      query_at(grid_n() - 1, grid_n() - 1);
      query(grid_n(), 0);
      query_at($urandom_range(0, grid_n() - 1), $urandom_range(0, grid_n() - 1));
    end
    drain();
  endtask

  task automatic test_random_traffic();
    int sent, n, phase_len;
    sent = 0;
    while (sent < 200) begin
      drain();
      set_config($urandom_range(3, 6), $urandom_range(0, 15), $urandom_range(0, 1),
                 pick_coef(), pick_coef(), pick_coef(), pick_coef());
      fill_grid();
      n = grid_n();
      phase_len = $urandom_range(30, 70);
      for (int i = 0; i < phase_len; i++) begin
        case ($urandom_range(0, 19))
          0, 1: load_cell($urandom_range(0, 63), $urandom_range(0, 63));
          2, 3: load_edge($urandom_range(0, 3), $urandom_range(0, 63));
          4: clear_sum();
          5: query($urandom_range(0, 63), $urandom_range(0, 63));
          default: query($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        endcase
        // hold off once per phase until every result is back
        if (i == phase_len / 2) begin
          @(negedge clk);
          in_push = 1'b0;
          while (resid_q.size() != 0) @(posedge clk);
        end
      end
      sent += n * n + 4 * n + phase_len;
    end
    drain();
  endtask

  // result side: stall now and then, sometimes for long
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_pop <= 1'b0;
    end else begin
      case ($urandom_range(0, 29))
        0: begin
          stall_left <= $urandom_range(10, 40);
          out_pop <= 1'b0;
        end
        1, 2, 3, 4, 5: out_pop <= 1'b0;
        default: out_pop <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    resid_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (resid_q.size() == 0) begin
        $display("%0t: unexpected result resid=%0d sum=%0h sat=%0b", $time,
                 out_resid_value, out_sum_squares, out_saturated);
        errors++;
      end else begin
        want = resid_q.pop_front();
        if (out_resid_value !== want.resid) begin
          $display("%0t: resid_value expected %0d actual %0d", $time, want.resid,
                   out_resid_value);
          errors++;
        end
        if (out_sum_squares !== want.sum) begin
          $display("%0t: sum_squares expected %0h actual %0h", $time, want.sum,
                   out_sum_squares);
          errors++;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, want.sat,
                   out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    accum_m = '0;
    gsize_m = 7'd64;
    nbr_m = '0;
    neu_m = 1'b0;
    ihx_m = 32'd256;
    ihx2_m = 32'd256;
    ihy_m = 32'd256;
    ihy2_m = 32'd256;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_full_grid_defaults();
    test_edge_stencils();
    test_saturation();
    test_grid_size_clamp();
    test_random_traffic();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
